// ----- sv/dmh_pkg.sv -----
// ----------------------------------------------------------------------------
// dmh_pkg
// Types and constants shared by the delta magnitude histogram blocks.
// ----------------------------------------------------------------------------
package dmh_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int COUNT_BITS  = 32;
  localparam int BIN_BITS    = 16;
  localparam int BIN_DEPTH   = 65536;
  localparam int STRIDE_BITS = 5;
  localparam int PHASE_BITS  = 4;
  localparam int STRIDE_MAX  = 16;
  localparam int UNIQUE_BITS = 17;

  typedef struct packed {
    logic               kind;
    logic signed [15:0] sample;
    logic               buffer_end;
  } dmh_item_t;

  typedef struct packed {
    logic        was_counted;
    logic [15:0] delta_magnitude;
    logic [31:0] total_count;
    logic [16:0] unique_deltas;
    logic [15:0] peak_delta;
    logic [31:0] most_frequent_count;
  } dmh_result_t;

  // item kind codes on the input port
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_CLEAR  = 1'b1;

  typedef enum logic [1:0] {
    OP_CLEAR,
    OP_SKIP,
    OP_COUNT
  } dmh_opcode_t;

  // classified work handed from the front end to the back end
  typedef struct packed {
    dmh_opcode_t           op;
    logic [BIN_BITS-1:0]   mag;
  } dmh_op_t;

  typedef enum logic [1:0] {
    B_SWEEP,
    B_IDLE,
    B_UPDATE
  } dmh_back_state_t;

  typedef struct packed {
    logic init_clear;
  } dmh_back_status_t;

endpackage

// ----- sv/dmh_ram.sv -----
// ----------------------------------------------------------------------------
// dmh_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module dmh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- sv/dmh_queue.sv -----
// ----------------------------------------------------------------------------
// dmh_queue
// Two-entry queue of classified words between the front and back ends.
// ----------------------------------------------------------------------------
module dmh_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  dmh_pkg::dmh_op_t push_word,
  output logic             full,
  input  logic             pop,
  output dmh_pkg::dmh_op_t pop_word,
  output logic             empty
);

  dmh_pkg::dmh_op_t entries [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       fill;
  logic             do_push;
  logic             do_pop;

  assign full     = (fill == 2'd2);
  assign empty    = (fill == 2'd0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_word = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 2'd1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_word;
    end
  end

endmodule

// ----- sv/dmh_front.sv -----
// ----------------------------------------------------------------------------
// dmh_front
// Accepts input words, tracks stride phase and previous kept sample, and
// classifies each word as clear, skip or count with its delta magnitude.
// ----------------------------------------------------------------------------
module dmh_front (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             push,
  input  dmh_pkg::dmh_item_t               item,
  output logic                             full,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [dmh_pkg::STRIDE_BITS-1:0]  cfg_data,
  input  dmh_pkg::dmh_back_status_t        back_status,
  output logic                             q_push,
  output dmh_pkg::dmh_op_t                 q_word,
  input  logic                             q_full
);

  logic [dmh_pkg::STRIDE_BITS-1:0] sample_stride;
  logic [dmh_pkg::PHASE_BITS-1:0]  stride_phase;
  logic [dmh_pkg::PHASE_BITS-1:0]  stride_phase_next;
  logic [dmh_pkg::SAMPLE_BITS-1:0] previous_sample;
  logic [dmh_pkg::STRIDE_BITS-1:0] stride_eff;
  logic [dmh_pkg::STRIDE_BITS-1:0] phase_inc;
  logic signed [dmh_pkg::SAMPLE_BITS:0] diff;
  logic [dmh_pkg::SAMPLE_BITS:0]   diff_abs;
  logic                            accept;

  assign cfg_ready = 1'b1;
  // no new words while the bins are being cleared after reset
  assign full   = q_full || back_status.init_clear;
  assign accept = push && !full;
  assign q_push = accept;

  always_comb begin
    if (sample_stride == '0) begin
      stride_eff = dmh_pkg::STRIDE_BITS'(1);
    end else if (sample_stride > dmh_pkg::STRIDE_BITS'(dmh_pkg::STRIDE_MAX)) begin
      stride_eff = dmh_pkg::STRIDE_BITS'(dmh_pkg::STRIDE_MAX);
    end else begin
      stride_eff = sample_stride;
    end
  end

  assign phase_inc = dmh_pkg::STRIDE_BITS'(stride_phase) + dmh_pkg::STRIDE_BITS'(1);

  always_comb begin
    if ((phase_inc >= stride_eff) || item.buffer_end) begin
      stride_phase_next = '0;
    end else begin
      stride_phase_next = phase_inc[dmh_pkg::PHASE_BITS-1:0];
    end
  end

  assign diff = $signed({item.sample[dmh_pkg::SAMPLE_BITS-1],
                         item.sample[dmh_pkg::SAMPLE_BITS-1:0]})
              - $signed({previous_sample[dmh_pkg::SAMPLE_BITS-1], previous_sample});
  assign diff_abs = diff[dmh_pkg::SAMPLE_BITS] ? 17'(-diff) : 17'(diff);

  always_comb begin
    q_word.mag = '0;
    if (item.kind == dmh_pkg::KIND_CLEAR) begin
      q_word.op = dmh_pkg::OP_CLEAR;
    end else if (stride_phase == '0) begin
      q_word.op  = dmh_pkg::OP_COUNT;
      q_word.mag = dmh_pkg::BIN_BITS'(diff_abs[dmh_pkg::SAMPLE_BITS-1:0]);
    end else begin
      q_word.op = dmh_pkg::OP_SKIP;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_stride   <= dmh_pkg::STRIDE_BITS'(1);
      stride_phase    <= '0;
      previous_sample <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        sample_stride <= cfg_data;
      end
      if (accept) begin
        if (item.kind == dmh_pkg::KIND_CLEAR) begin
          stride_phase    <= '0;
          previous_sample <= '0;
        end else begin
          stride_phase <= stride_phase_next;
          if (stride_phase == '0) begin
            previous_sample <= item.sample[dmh_pkg::SAMPLE_BITS-1:0];
          end
        end
      end
    end
  end

endmodule

// ----- sv/dmh_back.sv -----
// ----------------------------------------------------------------------------
// dmh_back
// Executes classified words: bin read-modify-write, statistics, clearing
// sweep of the bin memory, and the result output register.
// ----------------------------------------------------------------------------
module dmh_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       q_empty,
  input  dmh_pkg::dmh_op_t           q_word,
  output logic                       q_pop,
  output dmh_pkg::dmh_back_status_t  back_status,
  output logic                       empty,
  input  logic                       pop,
  output dmh_pkg::dmh_result_t       result
);

  localparam logic [dmh_pkg::COUNT_BITS-1:0] CountMax = '1;

  dmh_pkg::dmh_back_state_t         state;
  dmh_pkg::dmh_back_state_t         state_next;
  logic [dmh_pkg::BIN_BITS-1:0]     sweep_addr;
  logic                             init_clear;
  logic [dmh_pkg::COUNT_BITS-1:0]   delta_total;
  logic [dmh_pkg::UNIQUE_BITS-1:0]  nonzero_bins;
  logic [dmh_pkg::BIN_BITS-1:0]     largest_delta;
  logic [dmh_pkg::COUNT_BITS-1:0]   highest_count;
  logic [dmh_pkg::BIN_BITS-1:0]     cur_mag;
  logic                             out_valid;
  dmh_pkg::dmh_result_t             out_word;

  logic                             out_free;
  logic                             out_load;
  dmh_pkg::dmh_result_t             out_load_word;
  logic                             ram_we;
  logic [dmh_pkg::BIN_BITS-1:0]     ram_waddr;
  logic [dmh_pkg::COUNT_BITS-1:0]   ram_wdata;
  logic                             ram_re;
  logic [dmh_pkg::COUNT_BITS-1:0]   ram_rdata;
  logic [dmh_pkg::COUNT_BITS-1:0]   bin_next;
  logic                             clear_stats;
  logic                             apply_count;

  dmh_ram #(
    .WIDTH (dmh_pkg::COUNT_BITS),
    .DEPTH (dmh_pkg::BIN_DEPTH)
  ) u_bins (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (q_word.mag),
    .rdata (ram_rdata)
  );

  assign empty                  = !out_valid;
  assign result                 = out_word;
  assign out_free               = !out_valid || pop;
  assign back_status.init_clear = init_clear;

  assign bin_next = (ram_rdata == CountMax) ? ram_rdata : ram_rdata + 1'b1;

  always_comb begin
    state_next    = state;
    q_pop         = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = cur_mag;
    ram_wdata     = bin_next;
    ram_re        = 1'b0;
    out_load      = 1'b0;
    clear_stats   = 1'b0;
    apply_count   = 1'b0;
    out_load_word = '0;
    case (state)
      dmh_pkg::B_SWEEP: begin
        ram_we    = 1'b1;
        ram_waddr = sweep_addr;
        ram_wdata = '0;
        if (sweep_addr == '1) begin
          state_next = dmh_pkg::B_IDLE;
        end
      end
      dmh_pkg::B_IDLE: begin
        if (!q_empty && out_free) begin
          q_pop = 1'b1;
          case (q_word.op)
            dmh_pkg::OP_CLEAR: begin
              out_load    = 1'b1;
              clear_stats = 1'b1;
              state_next  = dmh_pkg::B_SWEEP;
            end
            dmh_pkg::OP_COUNT: begin
              ram_re     = 1'b1;
              state_next = dmh_pkg::B_UPDATE;
            end
            default: begin
              out_load = 1'b1;
              out_load_word.total_count         = 32'(delta_total);
              out_load_word.unique_deltas       = nonzero_bins;
              out_load_word.peak_delta          = largest_delta;
              out_load_word.most_frequent_count = 32'(highest_count);
            end
          endcase
        end
      end
      dmh_pkg::B_UPDATE: begin
        if (out_free) begin
          ram_we      = 1'b1;
          out_load    = 1'b1;
          apply_count = 1'b1;
          state_next  = dmh_pkg::B_IDLE;
          out_load_word.was_counted     = 1'b1;
          out_load_word.delta_magnitude = cur_mag;
          out_load_word.total_count     =
            32'((delta_total == CountMax) ? delta_total : delta_total + 1'b1);
          out_load_word.unique_deltas   =
            (ram_rdata == '0) ? nonzero_bins + 1'b1 : nonzero_bins;
          out_load_word.peak_delta      =
            (cur_mag > largest_delta) ? cur_mag : largest_delta;
          // highest_count bounds every bin, so only a tie can raise it
          out_load_word.most_frequent_count =
            32'(((ram_rdata == highest_count) && (ram_rdata != CountMax)) ?
                bin_next : highest_count);
        end
      end
      default: begin
        state_next = dmh_pkg::B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= dmh_pkg::B_SWEEP;
      sweep_addr    <= '0;
      init_clear    <= 1'b1;
      delta_total   <= '0;
      nonzero_bins  <= '0;
      largest_delta <= '0;
      highest_count <= '0;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (state == dmh_pkg::B_SWEEP) begin
        sweep_addr <= sweep_addr + 1'b1;
        if (sweep_addr == '1) begin
          init_clear <= 1'b0;
        end
      end
      if (clear_stats) begin
        sweep_addr    <= '0;
        delta_total   <= '0;
        nonzero_bins  <= '0;
        largest_delta <= '0;
        highest_count <= '0;
      end else if (apply_count) begin
        delta_total   <= dmh_pkg::COUNT_BITS'(out_load_word.total_count);
        nonzero_bins  <= out_load_word.unique_deltas;
        largest_delta <= out_load_word.peak_delta;
        highest_count <= dmh_pkg::COUNT_BITS'(out_load_word.most_frequent_count);
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_word <= out_load_word;
    end
    if (ram_re) begin
      cur_mag <= q_word.mag;
    end
  end

`ifndef SYNTHESIS
  a_no_read_in_sweep: assert property (@(posedge clk) disable iff (rst)
    (state == dmh_pkg::B_SWEEP) |-> !ram_re)
    else $error("bin read issued during clearing sweep");

  a_pop_only_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> (state == dmh_pkg::B_IDLE))
    else $error("queue popped outside idle state");

  a_peak_le_total: assert property (@(posedge clk) disable iff (rst)
    highest_count <= delta_total)
    else $error("highest bin count exceeds total");

  a_no_bins_no_peak: assert property (@(posedge clk) disable iff (rst)
    (nonzero_bins == '0) |-> (largest_delta == '0))
    else $error("peak delta set with no nonzero bins");

  a_update_after_read: assert property (@(posedge clk) disable iff (rst)
    ((state == dmh_pkg::B_UPDATE) && !$past(state == dmh_pkg::B_UPDATE))
      |-> $past(ram_re))
    else $error("update state entered without a bin read");
`endif

endmodule

// ----- sv/delta_magnitude_histogram.sv -----
// ----------------------------------------------------------------------------
// delta_magnitude_histogram
// Histogram of absolute differences between successive kept audio samples.
// ----------------------------------------------------------------------------
// sequence: a counted sample is popped in B_IDLE with a bin ram read and its
//   result loaded in B_UPDATE; a skipped sample or a clear loads its result on
//   pop, when the back end is free. A counted sample holds the back end for the
//   bin ram read, then the write; a clear holds it while it sweeps all 65536 bins
// reset: full stays high during the bin clearing pass after reset
module delta_magnitude_histogram (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             push,
  input  dmh_pkg::dmh_item_t               item,
  output logic                             full,
  output logic                             empty,
  input  logic                             pop,
  output dmh_pkg::dmh_result_t             result,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [dmh_pkg::STRIDE_BITS-1:0]  cfg_data
);

  dmh_pkg::dmh_back_status_t back_status;
  logic                      q_push;
  dmh_pkg::dmh_op_t          q_push_word;
  logic                      q_full;
  logic                      q_pop;
  dmh_pkg::dmh_op_t          q_pop_word;
  logic                      q_empty;

  dmh_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .item        (item),
    .full        (full),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .back_status (back_status),
    .q_push      (q_push),
    .q_word      (q_push_word),
    .q_full      (q_full)
  );

  dmh_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_word (q_push_word),
    .full      (q_full),
    .pop       (q_pop),
    .pop_word  (q_pop_word),
    .empty     (q_empty)
  );

  dmh_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_empty     (q_empty),
    .q_word      (q_pop_word),
    .q_pop       (q_pop),
    .back_status (back_status),
    .empty       (empty),
    .pop         (pop),
    .result      (result)
  );

endmodule
